[rtl/itp_pkg.sv]
// Shared types, character codes and helpers for the infix to prefix operator stack.
`default_nettype none

package itp_pkg;

    // Operator codes as they sit in the stack memory.
    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_CLOSE = 3'd4
    } op_t;

    // Latched error codes.
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_PAREN    = 2'd2
    } err_t;

    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    // Character that a popped operator code stands for.
    function automatic logic [7:0] op_char(input logic [2:0] code);
        logic [7:0] ch;
        case (code)
            OP_ADD:  ch = CH_ADD;
            OP_SUB:  ch = CH_SUB;
            OP_MUL:  ch = CH_MUL;
            OP_DIV:  ch = CH_DIV;
            default: ch = CH_CLOSE;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

[rtl/infix_to_prefix_operator_stack.sv]
// Top level of the infix to prefix converter with its operator stack and result buffer.
//
//   Channel  Direction  Handshake              Payload
//   input    in         in_valid / in_stall    in_char, end_of_expr
//   output   out        out_valid / out_stall  out_char, has_char, run_last, expr_done,
//                                              error_code
//
// A request is taken only while the sequencer is idle, so in_stall is high for the
// whole time that one character is being worked on and its results are delivered.
// After a request is accepted the sequencer decodes it, pops each stack entry taken by
// '+', '-', '(' or the end-of-expression flush (a matching ')' counts as popped), pushes
// '+' or '-', notes when '(' or the flush finds the stack empty, settles before a flush
// that follows '*', '/', ')', '+' or '-', finishes, and then delivers each result by a
// buffer read and the output register, or a bare end marker, subject to output stalls;
// the next request is taken once the sequencer is back in idle.
// The single read port of the stack memory sets the one-pop-per-cycle rate.
// Reset clears the stack count, the error latch, the sequencer and the output valid;
// the stack and result memories hold nothing meaningful until written.
//
// Results of one request are first collected in a small buffer, because the error
// code that every result carries is only known once the whole request is handled,
// and the final result has to be marked as such. They are then played out in order.
`default_nettype none

module infix_to_prefix_operator_stack
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output      logic       in_stall,
    input  wire logic [7:0] in_char,
    input  wire logic       end_of_expr,

    output      logic       out_valid,
    input  wire logic       out_stall,
    output      logic [7:0] out_char,
    output      logic       has_char,
    output      logic       run_last,
    output      logic       expr_done,
    output      logic [1:0] error_code
);

    // Stack memory address and count widths.
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    // A request yields at most one result more than the stack holds.
    localparam int RES_DEPTH = STACK_DEPTH + 1;
    localparam int RAW = $clog2(RES_DEPTH);
    localparam int RCW = $clog2(RES_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_PLUS,
        S_OPEN,
        S_SETTLE,
        S_FLUSH,
        S_FINISH,
        S_LOAD,
        S_OUT
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    err_t           err_reg, err_next;
    logic [7:0]     char_reg, char_next;
    logic           end_reg, end_next;
    logic [RCW-1:0] rcnt_reg, rcnt_next;
    logic [RAW-1:0] ridx_reg, ridx_next;

    logic           out_valid_reg, out_valid_next;
    logic [7:0]     out_char_reg, out_char_next;
    logic           has_char_reg, has_char_next;
    logic           run_last_reg, run_last_next;
    logic           expr_done_reg, expr_done_next;
    logic [1:0]     error_code_reg, error_code_next;

    // Stack memory ports.
    logic           stk_we;
    logic [AW-1:0]  stk_waddr;
    logic [2:0]     stk_wdata;
    logic [AW-1:0]  stk_raddr;
    logic [2:0]     stk_rdata;
    logic [CW-1:0]  top_idx;

    // Result buffer ports.
    logic           res_we;
    logic [7:0]     res_wdata;
    logic [7:0]     res_rdata;

    logic           stack_empty;
    logic           stack_full;
    logic           top_is_muldiv;
    logic           top_is_close;
    logic [RCW-1:0] rcnt_last;
    logic           in_accept;
    logic           out_accept;

    // The stack is read at the top of the count that the next cycle will have, so
    // after a pop the new top is ready in the cycle after it. A push writes the old read
    // address, which is why a flush that follows a push waits in the settle state.
    assign top_idx   = cnt_next - 1'b1;
    assign stk_raddr = top_idx[AW-1:0];
    assign stk_waddr = cnt_reg[AW-1:0];

    itp_ram #(
        .WIDTH (3),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    itp_ram #(
        .WIDTH (8),
        .DEPTH (RES_DEPTH)
    ) u_results (
        .clk   (clk),
        .we    (res_we),
        .waddr (rcnt_reg[RAW-1:0]),
        .wdata (res_wdata),
        .raddr (ridx_next),
        .rdata (res_rdata)
    );

    assign stack_empty   = (cnt_reg == '0);
    assign stack_full    = (cnt_reg == CW'(STACK_DEPTH));
    assign top_is_muldiv = !stack_empty &&
                           (stk_rdata == OP_MUL || stk_rdata == OP_DIV);
    assign top_is_close  = !stack_empty && (stk_rdata == OP_CLOSE);
    assign rcnt_last     = rcnt_reg - 1'b1;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        err_next        = err_reg;
        char_next       = char_reg;
        end_next        = end_reg;
        rcnt_next       = rcnt_reg;
        ridx_next       = ridx_reg;
        out_valid_next  = out_valid_reg;
        out_char_next   = out_char_reg;
        has_char_next   = has_char_reg;
        run_last_next   = run_last_reg;
        expr_done_next  = expr_done_reg;
        error_code_next = error_code_reg;
        stk_we          = 1'b0;
        stk_wdata       = OP_ADD;
        res_we          = 1'b0;
        res_wdata       = op_char(stk_rdata);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    char_next  = in_char;
                    end_next   = end_of_expr;
                    rcnt_next  = '0;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                case (char_reg) inside
                    CH_MUL, CH_DIV, CH_CLOSE:
                    begin
                        if (stack_full)
                        begin
                            if (err_reg == ERR_NONE)
                            begin
                                err_next = ERR_OVERFLOW;
                            end
                        end
                        else
                        begin
                            stk_we   = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                        end
                        if (char_reg == CH_MUL)
                        begin
                            stk_wdata = OP_MUL;
                        end
                        else if (char_reg == CH_DIV)
                        begin
                            stk_wdata = OP_DIV;
                        end
                        else
                        begin
                            stk_wdata = OP_CLOSE;
                        end
                        state_next = end_reg ? S_SETTLE : S_FINISH;
                    end
                    CH_ADD, CH_SUB:
                    begin
                        state_next = S_PLUS;
                    end
                    CH_OPEN:
                    begin
                        state_next = S_OPEN;
                    end
                    default:
                    begin
                        // Anything else is an operand and goes straight out.
                        res_we     = 1'b1;
                        res_wdata  = char_reg;
                        rcnt_next  = rcnt_reg + 1'b1;
                        state_next = end_reg ? S_FLUSH : S_FINISH;
                    end
                endcase
            end

            S_PLUS:
            begin
                if (top_is_muldiv)
                begin
                    res_we    = 1'b1;
                    rcnt_next = rcnt_reg + 1'b1;
                    cnt_next  = cnt_reg - 1'b1;
                end
                else
                begin
                    if (stack_full)
                    begin
                        if (err_reg == ERR_NONE)
                        begin
                            err_next = ERR_OVERFLOW;
                        end
                    end
                    else
                    begin
                        stk_we   = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    stk_wdata  = (char_reg == CH_ADD) ? OP_ADD : OP_SUB;
                    state_next = end_reg ? S_SETTLE : S_FINISH;
                end
            end

            S_OPEN:
            begin
                if (stack_empty)
                begin
                    if (err_reg == ERR_NONE)
                    begin
                        err_next = ERR_PAREN;
                    end
                    state_next = end_reg ? S_FLUSH : S_FINISH;
                end
                else if (top_is_close)
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = end_reg ? S_FLUSH : S_FINISH;
                end
                else
                begin
                    res_we    = 1'b1;
                    rcnt_next = rcnt_reg + 1'b1;
                    cnt_next  = cnt_reg - 1'b1;
                end
            end

            S_SETTLE:
            begin
                state_next = S_FLUSH;
            end

            S_FLUSH:
            begin
                if (stack_empty)
                begin
                    state_next = S_FINISH;
                end
                else if (top_is_close)
                begin
                    // A close left over at the end is dropped and flagged.
                    cnt_next = cnt_reg - 1'b1;
                    if (err_reg == ERR_NONE)
                    begin
                        err_next = ERR_PAREN;
                    end
                end
                else
                begin
                    res_we    = 1'b1;
                    rcnt_next = rcnt_reg + 1'b1;
                    cnt_next  = cnt_reg - 1'b1;
                end
            end

            S_FINISH:
            begin
                if (rcnt_reg != '0)
                begin
                    ridx_next  = '0;
                    state_next = S_LOAD;
                end
                else if (end_reg)
                begin
                    // An end that produced no character still closes the expression.
                    out_valid_next  = 1'b1;
                    out_char_next   = '0;
                    has_char_next   = 1'b0;
                    run_last_next   = 1'b1;
                    expr_done_next  = 1'b1;
                    error_code_next = err_reg;
                    state_next      = S_OUT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_LOAD:
            begin
                out_valid_next  = 1'b1;
                out_char_next   = res_rdata;
                has_char_next   = 1'b1;
                run_last_next   = (RCW'(ridx_reg) == rcnt_last);
                expr_done_next  = (RCW'(ridx_reg) == rcnt_last) && end_reg;
                error_code_next = err_reg;
                state_next      = S_OUT;
            end

            S_OUT:
            begin
                if (out_accept)
                begin
                    out_valid_next = 1'b0;
                    if (run_last_reg)
                    begin
                        if (end_reg)
                        begin
                            err_next = ERR_NONE;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ridx_next  = ridx_reg + 1'b1;
                        state_next = S_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            err_reg        <= ERR_NONE;
            char_reg       <= '0;
            end_reg        <= 1'b0;
            rcnt_reg       <= '0;
            ridx_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_char_reg   <= '0;
            has_char_reg   <= 1'b0;
            run_last_reg   <= 1'b0;
            expr_done_reg  <= 1'b0;
            error_code_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            err_reg        <= err_next;
            char_reg       <= char_next;
            end_reg        <= end_next;
            rcnt_reg       <= rcnt_next;
            ridx_reg       <= ridx_next;
            out_valid_reg  <= out_valid_next;
            out_char_reg   <= out_char_next;
            has_char_reg   <= has_char_next;
            run_last_reg   <= run_last_next;
            expr_done_reg  <= expr_done_next;
            error_code_reg <= error_code_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign has_char   = has_char_reg;
    assign run_last   = run_last_reg;
    assign expr_done  = expr_done_reg;
    assign error_code = error_code_reg;

    // A new request is never taken while a result is still on offer.
    a_no_accept_while_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
        else $error("input ready while a result is pending");

    // The stack count never goes past the stack depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // The end of an expression is always the final result of its request.
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && expr_done |-> run_last)
        else $error("expression end not marked as last result");

    // Once the end of an expression is delivered, the stack and the error are clear.
    a_clean_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && expr_done |=> cnt_reg == '0 && err_reg == ERR_NONE)
        else $error("state not cleared after end of expression");

endmodule

`default_nettype wire

[rtl/itp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents when both ports hit the same address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
